[hw/rtl/tq_pkg.sv]
`default_nettype none

package tq_pkg;

   // Request operation codes
   typedef enum logic [1:0] {
      OP_BACK   = 2'd0,
      OP_FRONT  = 2'd1,
      OP_MIDDLE = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   // Response status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned INDEX_W = 10;

   typedef struct packed {
      op_type                     op;
      logic signed [DATA_W-1:0]   value;
      logic        [INDEX_W-1:0]  index;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]   read_value;
      status_type                 status;
   } rsp_type;

endpackage

`default_nettype wire

[hw/rtl/tq_ram.sv]
`default_nettype none

module tq_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, register one read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/tq_ring_unit.sv]
`default_nettype none

module tq_ring_unit #(
   parameter int unsigned CAPACITY = 1024
) (
   input  wire logic [$clog2(CAPACITY)-1:0] base,
   input  wire logic [$clog2(CAPACITY)-1:0] offset,
   output logic      [$clog2(CAPACITY)-1:0] pos
);

   localparam int unsigned AW = $clog2(CAPACITY);

   logic [AW:0] sum;
   logic [AW:0] wrapped;

   // Add within the ring, one conditional subtract wraps it
   always_comb begin
      sum     = {1'b0, base} + {1'b0, offset};
      wrapped = sum - (AW+1)'(CAPACITY);
      if (sum >= (AW+1)'(CAPACITY)) begin
         pos = wrapped[AW-1:0];
      end else begin
         pos = sum[AW-1:0];
      end
   end

endmodule

`default_nettype wire

[hw/rtl/three_ended_queue.sv]
// Channel   | Ports                        | Handshake
// ----------+------------------------------+-----------------------------------
// request   | start, busy, req_payload     | taken when start && !busy
// response  | rsp_strobe, rsp_payload      | one cycle per response, no stall
//
// A request runs through these steps before the next one is taken: refused push
// or out-of-range read (take, check), read (take, address, memory data), push
// (take, write, balance check), push plus half move (then move). One ring address
// adder serves all addressing steps; each half is one memory with a registered read.
// Synchronous reset empties the queue at once; the stores need no clearing.
// The response leaves from a register while the next request is taken.
`default_nettype none

module three_ended_queue
   import tq_pkg::*;
#(
   parameter int unsigned CAPACITY    = 1024,
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_payload,
   output logic         rsp_strobe,
   output rsp_type      rsp_payload
);

   localparam int unsigned AW    = $clog2(CAPACITY);
   localparam int unsigned CW    = $clog2(CAPACITY + 1);
   localparam int unsigned CMP_W = (CW > INDEX_W) ? CW : INDEX_W;
   localparam logic [AW-1:0] STEP_BACK = AW'(CAPACITY - 1);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_EXEC  = 5'b00010,
      S_RDATA = 5'b00100,
      S_BAL   = 5'b01000,
      S_MOVE  = 5'b10000
   } state_type;

   state_type               state_ff, state_in;
   op_type                  op_ff, op_in;
   logic [VALUE_WIDTH-1:0]  value_ff, value_in;
   logic [INDEX_W-1:0]      index_ff, index_in;
   logic [AW-1:0]           fs_ff, fs_in;
   logic [AW-1:0]           bs_ff, bs_in;
   logic [CW-1:0]           fc_ff, fc_in;
   logic [CW-1:0]           bc_ff, bc_in;
   logic                    to_front_ff, to_front_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   rsp_type                 rsp_ff, rsp_in;

   logic [AW-1:0]           unit_base;
   logic [AW-1:0]           unit_offset;
   logic [AW-1:0]           unit_pos;

   logic                    f_we, f_re, b_we, b_re;
   logic [AW-1:0]           f_waddr, f_raddr, b_waddr, b_raddr;
   logic [VALUE_WIDTH-1:0]  f_wdata, b_wdata, f_rdata, b_rdata, rd_sel;

   logic [CW-1:0]           count;
   logic                    full;
   logic [CMP_W-1:0]        idx_ext, n_ext, fc_ext;
   logic                    in_range, idx_front;
   logic                    grow_front, grow_back;

   // Shared ring address adder
   tq_ring_unit #(
      .CAPACITY (CAPACITY)
   ) u_ring (
      .base   (unit_base),
      .offset (unit_offset),
      .pos    (unit_pos)
   );

   tq_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (CAPACITY)
   ) u_front_ram (
      .clock   (clock),
      .wr_en   (f_we),
      .wr_addr (f_waddr),
      .wr_data (f_wdata),
      .rd_en   (f_re),
      .rd_addr (f_raddr),
      .rd_data (f_rdata)
   );

   tq_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (CAPACITY)
   ) u_back_ram (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (b_waddr),
      .wr_data (b_wdata),
      .rd_en   (b_re),
      .rd_addr (b_raddr),
      .rd_data (b_rdata)
   );

   // Size and range checks
   always_comb begin
      count      = fc_ff + bc_ff;
      full       = (count == CW'(CAPACITY));
      idx_ext    = CMP_W'(index_ff);
      n_ext      = CMP_W'(count);
      fc_ext     = CMP_W'(fc_ff);
      in_range   = (idx_ext < n_ext);
      idx_front  = (idx_ext < fc_ext);
      grow_front = (bc_ff > fc_ff);
      grow_back  = ((CW+1)'(fc_ff) > ((CW+1)'(bc_ff) + (CW+1)'(1)));
      rd_sel     = to_front_ff ? f_rdata : b_rdata;
   end

   // Sequencer: pick adder operands, drive memories, step state
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      value_in      = value_ff;
      index_in      = index_ff;
      fs_in         = fs_ff;
      bs_in         = bs_ff;
      fc_in         = fc_ff;
      bc_in         = bc_ff;
      to_front_in   = to_front_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      unit_base     = fs_ff;
      unit_offset   = '0;
      f_we          = 1'b0;
      f_re          = 1'b0;
      b_we          = 1'b0;
      b_re          = 1'b0;
      f_waddr       = unit_pos;
      b_waddr       = unit_pos;
      f_raddr       = unit_pos;
      b_raddr       = unit_pos;
      f_wdata       = value_ff;
      b_wdata       = value_ff;

      unique case (state_ff)
         S_IDLE: begin
            // Take a request
            if (start) begin
               op_in    = req_payload.op;
               value_in = VALUE_WIDTH'($signed(req_payload.value));
               index_in = req_payload.index;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            if (op_ff == OP_READ) begin
               if (!in_range) begin
                  rsp_strobe_in     = 1'b1;
                  rsp_in.read_value = '0;
                  rsp_in.status     = ST_RANGE;
                  state_in          = S_IDLE;
               end else begin
                  // Issue the read on the half that holds the index
                  to_front_in = idx_front;
                  if (idx_front) begin
                     unit_base   = fs_ff;
                     unit_offset = AW'(idx_ext);
                     f_re        = 1'b1;
                  end else begin
                     unit_base   = bs_ff;
                     unit_offset = AW'(idx_ext - fc_ext);
                     b_re        = 1'b1;
                  end
                  state_in = S_RDATA;
               end
            end else if (full) begin
               // Drop the push
               rsp_strobe_in     = 1'b1;
               rsp_in.read_value = '0;
               rsp_in.status     = ST_FULL;
               state_in          = S_IDLE;
            end else begin
               unique case (op_ff)
                  OP_BACK: begin
                     unit_base   = bs_ff;
                     unit_offset = AW'(bc_ff);
                     b_we        = 1'b1;
                     bc_in       = bc_ff + CW'(1);
                  end
                  OP_FRONT: begin
                     unit_base   = fs_ff;
                     unit_offset = STEP_BACK;
                     f_we        = 1'b1;
                     fs_in       = unit_pos;
                     fc_in       = fc_ff + CW'(1);
                  end
                  default: begin
                     // Middle push lands at the end of the front half
                     unit_base   = fs_ff;
                     unit_offset = AW'(fc_ff);
                     f_we        = 1'b1;
                     fc_in       = fc_ff + CW'(1);
                  end
               endcase
               state_in = S_BAL;
            end
         end

         S_RDATA: begin
            rsp_strobe_in     = 1'b1;
            rsp_in.read_value = DATA_W'($signed(rd_sel));
            rsp_in.status     = ST_OK;
            state_in          = S_IDLE;
         end

         S_BAL: begin
            priority if (grow_front) begin
               // Pop the head of the back half
               unit_base   = bs_ff;
               unit_offset = AW'(1);
               b_re        = 1'b1;
               b_raddr     = bs_ff;
               bs_in       = unit_pos;
               bc_in       = bc_ff - CW'(1);
               to_front_in = 1'b1;
               state_in    = S_MOVE;
            end else if (grow_back) begin
               // Pop the tail of the front half
               unit_base   = fs_ff;
               unit_offset = AW'(fc_ff - CW'(1));
               f_re        = 1'b1;
               fc_in       = fc_ff - CW'(1);
               to_front_in = 1'b0;
               state_in    = S_MOVE;
            end else begin
               state_in = S_IDLE;
            end
         end

         S_MOVE: begin
            if (to_front_ff) begin
               unit_base   = fs_ff;
               unit_offset = AW'(fc_ff);
               f_we        = 1'b1;
               f_wdata     = b_rdata;
               fc_in       = fc_ff + CW'(1);
            end else begin
               unit_base   = bs_ff;
               unit_offset = STEP_BACK;
               b_we        = 1'b1;
               b_wdata     = f_rdata;
               bs_in       = unit_pos;
               bc_in       = bc_ff + CW'(1);
            end
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         fs_ff         <= '0;
         bs_ff         <= '0;
         fc_ff         <= '0;
         bc_ff         <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fs_ff         <= fs_in;
         bs_ff         <= bs_in;
         fc_ff         <= fc_in;
         bc_ff         <= bc_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      value_ff    <= value_in;
      index_ff    <= index_in;
      to_front_ff <= to_front_in;
      rsp_ff      <= rsp_in;
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire
